FILE: rtl/block_silence_segmenter_unit_assert.svh
// Assertion macros used by the segmenter queue (bss_queue).
// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef BLOCK_SILENCE_SEGMENTER_UNIT_ASSERT_SVH
`define BLOCK_SILENCE_SEGMENTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bss_pkg.sv
package bss_pkg;

    localparam int SAMPLE_W = 32;
    localparam int DIV_W    = 18;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 17;
    localparam int THR_W    = 31;
    localparam int LEVEL_W  = 31;
    localparam int MEAN_W   = 32;
    localparam int LEN_W    = 32;
    localparam int EVENT_W  = 2;

    localparam int FRONT_ITER_W = $clog2(SAMPLE_W);
    localparam int BACK_ITER_W  = $clog2(SUM_W);

    localparam logic [CNT_W-1:0] MAX_BLOCK_FRAMES = CNT_W'(65536);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam int OUT_DATA_W = 88;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BLOCK_FRAMES = 3'd0,
        REG_LEVEL_THRESH = 3'd1,
        REG_RATE_DIVISOR = 3'd2,
        REG_MIN_FRAMES   = 3'd3,
        REG_MAX_FRAMES   = 3'd4
    } t_reg_idx;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_KEPT  = 2'd1,
        EV_SHORT = 2'd2,
        EV_LONG  = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_ACC
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic [CNT_W-1:0] block_frames;
        logic [THR_W-1:0] level_threshold;
        logic [DIV_W-1:0] rate_divisor;
        logic [LEN_W-1:0] min_frames;
        logic [LEN_W-1:0] max_frames;
    } t_cfg;

    // One finished block handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_blk;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

FILE: rtl/bss_front.sv
module bss_front
    import bss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  logic [SAMPLE_W-1:0] i_s_sample,
    input  logic                i_s_last,
    input  t_queue_status       i_q_status,
    output logic                o_push,
    output t_blk                o_blk
);

    t_front_state r_state, n_state;

    logic [SAMPLE_W-1:0]     r_dvd;
    logic [DIV_W-1:0]        r_rem;
    logic [FRONT_ITER_W-1:0] r_iter;
    logic                    r_last;
    logic [SUM_W-1:0]        r_sum;
    logic [CNT_W-1:0]        r_cnt;

    logic [SAMPLE_W-1:0] mag;
    logic [DIV_W-1:0]    div_eff;
    logic [DIV_W:0]      trial;
    logic                q_bit;
    logic [DIV_W-1:0]    n_rem;
    logic [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]    n_cnt;
    logic [CNT_W-1:0]    eff_block;
    logic                blk_end;
    logic                advance;

    // Two's complement magnitude; the most negative value maps onto itself.
    assign mag     = i_s_sample[SAMPLE_W-1] ? (~i_s_sample + SAMPLE_W'(1)) : i_s_sample;
    assign div_eff = (i_cfg.rate_divisor == '0) ? DIV_W'(1) : i_cfg.rate_divisor;

    // One restoring division step per cycle, quotient bits shift into r_dvd.
    assign trial = {r_rem, r_dvd[SAMPLE_W-1]};
    assign q_bit = (trial >= {1'b0, div_eff});
    assign n_rem = q_bit ? DIV_W'(trial - {1'b0, div_eff}) : trial[DIV_W-1:0];

    always_comb begin
        eff_block = i_cfg.block_frames;
        if (i_cfg.block_frames == '0) begin
            eff_block = CNT_W'(1);
        end else if (i_cfg.block_frames > MAX_BLOCK_FRAMES) begin
            eff_block = MAX_BLOCK_FRAMES;
        end
    end

    assign n_sum   = r_sum + {{(SUM_W-SAMPLE_W){1'b0}}, r_dvd};
    assign n_cnt   = r_cnt + CNT_W'(1);
    assign blk_end = (n_cnt >= eff_block) || r_last;
    assign advance = (r_state == FR_ACC) && !(blk_end && i_q_status.full);

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: begin
                if (i_s_valid) begin
                    n_state = FR_DIV;
                end
            end
            FR_DIV: begin
                if (r_iter == '1) begin
                    n_state = FR_ACC;
                end
            end
            FR_ACC: begin
                if (advance) begin
                    n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready = 1'b0;
        o_push    = 1'b0;
        case (r_state)
            FR_IDLE: o_s_ready = 1'b1;
            FR_ACC:  o_push    = blk_end && !i_q_status.full;
            default: begin
                o_s_ready = 1'b0;
                o_push    = 1'b0;
            end
        endcase
    end

    assign o_blk.sum   = n_sum;
    assign o_blk.count = n_cnt;
    assign o_blk.last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                // Clear the block sums once the block has gone to the queue.
                r_sum <= blk_end ? '0 : n_sum;
                r_cnt <= blk_end ? '0 : n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FR_IDLE && i_s_valid) begin
            r_dvd  <= mag;
            r_rem  <= '0;
            r_iter <= '0;
            r_last <= i_s_last;
        end else if (r_state == FR_DIV) begin
            r_dvd  <= {r_dvd[SAMPLE_W-2:0], q_bit};
            r_rem  <= n_rem;
            r_iter <= r_iter + FRONT_ITER_W'(1);
        end
    end

endmodule

FILE: rtl/bss_queue.sv
`include "block_silence_segmenter_unit_assert.svh"

module bss_queue
    import bss_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_blk          i_blk,
    input  logic          i_pop,
    output t_blk          o_blk,
    output t_queue_status o_status
);

    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    t_blk                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_blk           = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == CNT_FULL);

    // Pointers wrap naturally: the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QUEUE_CNT_W'(1);
                2'b01:   r_count <= r_count - QUEUE_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_blk;
        end
    end

    `BSS_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, r_count != CNT_FULL, "queue push while full")
    `BSS_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "queue pop while empty")
    `BSS_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + QUEUE_CNT_W'(1), "queue count did not advance on push")

endmodule

FILE: rtl/bss_back.sv
module bss_back
    import bss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_queue_status       i_q_status,
    input  t_blk                i_blk,
    output logic                o_pop,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic                o_noisy,
    output logic [LEVEL_W-1:0]  o_level,
    output logic [CNT_W-1:0]    o_count,
    output logic [EVENT_W-1:0]  o_event,
    output logic [LEN_W-1:0]    o_frames,
    output logic                o_end
);

    t_back_state r_state, n_state;

    logic [SUM_W-1:0]       r_dvd;
    logic [CNT_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_den;
    logic [BACK_ITER_W-1:0] r_iter;
    logic                   r_last;

    logic             r_seg_open;
    logic [LEN_W-1:0] r_seg_len;

    logic               r_out_valid;
    logic               r_noisy;
    logic [LEVEL_W-1:0] r_level;
    logic [CNT_W-1:0]   r_count;
    t_event             r_event;
    logic [LEN_W-1:0]   r_frames;
    logic               r_end;

    logic [CNT_W:0]    trial;
    logic              q_bit;
    logic [CNT_W-1:0]  n_rem;
    logic              div_done;
    logic [MEAN_W-1:0] mean;
    logic              noisy;
    logic [LEN_W:0]    len_sum;
    logic [LEN_W-1:0]  n_len;
    logic              n_open;
    logic              closing;
    t_event            n_event;
    logic              slot_free;
    logic              finish;

    assign trial    = {r_rem, r_dvd[SUM_W-1]};
    assign q_bit    = (trial >= {1'b0, r_den});
    assign n_rem    = q_bit ? CNT_W'(trial - {1'b0, r_den}) : trial[CNT_W-1:0];
    assign div_done = (r_iter == BACK_ITER_W'(SUM_W - 1));

    // Each scaled magnitude is at most 2^31, so the mean fits in 32 bits.
    assign mean  = r_dvd[MEAN_W-1:0];
    assign noisy = (mean > {1'b0, i_cfg.level_threshold});

    assign len_sum = {1'b0, r_seg_len} + {{(LEN_W+1-CNT_W){1'b0}}, r_den};
    assign n_open  = r_seg_open || noisy;
    assign closing = n_open && (!noisy || r_last);

    always_comb begin
        n_len = r_seg_len;
        if (noisy) begin
            n_len = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
        end
    end

    always_comb begin
        if (n_len < i_cfg.min_frames) begin
            n_event = EV_SHORT;
        end else if (n_len > i_cfg.max_frames) begin
            n_event = EV_LONG;
        end else begin
            n_event = EV_KEPT;
        end
    end

    assign slot_free = !r_out_valid || i_m_ready;
    assign finish    = (r_state == BK_DONE) && slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = !i_q_status.empty;
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_seg_open  <= 1'b0;
            r_seg_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_out_valid <= 1'b1;
                r_seg_open  <= closing ? 1'b0 : n_open;
                r_seg_len   <= closing ? '0 : n_len;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dvd  <= i_blk.sum;
            r_den  <= i_blk.count;
            r_last <= i_blk.last;
            r_rem  <= '0;
            r_iter <= '0;
        end else if (r_state == BK_DIV) begin
            r_dvd  <= {r_dvd[SUM_W-2:0], q_bit};
            r_rem  <= n_rem;
            r_iter <= r_iter + BACK_ITER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_noisy  <= noisy;
            r_level  <= mean[MEAN_W-1] ? '1 : mean[LEVEL_W-1:0];
            r_count  <= r_den;
            r_event  <= closing ? n_event : EV_NONE;
            r_frames <= n_open ? n_len : '0;
            r_end    <= r_last;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_noisy   = r_noisy;
    assign o_level   = r_level;
    assign o_count   = r_count;
    assign o_event   = r_event;
    assign o_frames  = r_frames;
    assign o_end     = r_end;

endmodule

FILE: rtl/block_silence_segmenter_unit.sv
// Channel   Direction  Payload (lowest bit first)                          Accepted when
// s_axis    in         tdata: sample[31:0]; tlast: last_sample             tvalid && tready
// m_axis    out        tdata: block_noisy, block_level[30:0],              tvalid && tready
//                      block_count[16:0], segment_frames[31:0], zero pad;
//                      tuser: segment_event[1:0]; tlast: stream_end
// apb       in/out     five registers at byte addresses 0,4,8,12,16        psel && penable
//                                                                          && pwrite && pready
//
// Front: FR_IDLE accepts a sample, FR_DIV runs the bit-per-cycle restoring
// divide by rate_divisor, FR_ACC accumulates and waits while the block ends
// and the queue is full. Back: BK_IDLE pops a block, BK_DIV runs the
// bit-per-cycle divide of the 48-bit block sum by the sample count, BK_DONE
// judges the block and loads the output register once the slot is free.
// A two-entry block queue between front and back lets samples keep flowing
// while the back divides or the output stalls; with short blocks the back
// sets the pace and the front holds tready low while the queue is full.
// Reset (synchronous, active low) clears sums, counts, segment state and the
// queue, and loads the configuration defaults; no clearing pass follows.
module block_silence_segmenter_unit
    import bss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // stream in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
    input  logic                  s_axis_tlast,
    // stream out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] block_noisy, [31:1] block_level,
                                                  // [48:32] block_count,
                                                  // [80:49] segment_frames, [87:81] zero
    output logic [EVENT_W-1:0]    m_axis_tuser,   // [1:0] segment_event
    output logic                  m_axis_tlast,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg r_cfg;

    t_reg_idx reg_idx;
    logic     cfg_write;

    t_queue_status q_status;
    t_blk          push_blk;
    t_blk          pop_blk;
    logic          push;
    logic          pop;

    logic               out_noisy;
    logic [LEVEL_W-1:0] out_level;
    logic [CNT_W-1:0]   out_count;
    logic [EVENT_W-1:0] out_event;
    logic [LEN_W-1:0]   out_frames;
    logic               out_end;

    // Decode the word address; byte offset bits are ignored.
    assign reg_idx   = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_frames    <= CNT_W'(1024);
            r_cfg.level_threshold <= THR_W'(30);
            r_cfg.rate_divisor    <= DIV_W'(44100);
            r_cfg.min_frames      <= LEN_W'(44100);
            r_cfg.max_frames      <= LEN_W'(441000);
        end else if (cfg_write) begin
            // Unlisted addresses drop the write.
            case (reg_idx)
                REG_BLOCK_FRAMES: r_cfg.block_frames    <= pwdata[CNT_W-1:0];
                REG_LEVEL_THRESH: r_cfg.level_threshold <= pwdata[THR_W-1:0];
                REG_RATE_DIVISOR: r_cfg.rate_divisor    <= pwdata[DIV_W-1:0];
                REG_MIN_FRAMES:   r_cfg.min_frames      <= pwdata[LEN_W-1:0];
                REG_MAX_FRAMES:   r_cfg.max_frames      <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BLOCK_FRAMES: prdata = APB_DATA_W'(r_cfg.block_frames);
            REG_LEVEL_THRESH: prdata = APB_DATA_W'(r_cfg.level_threshold);
            REG_RATE_DIVISOR: prdata = APB_DATA_W'(r_cfg.rate_divisor);
            REG_MIN_FRAMES:   prdata = r_cfg.min_frames;
            REG_MAX_FRAMES:   prdata = r_cfg.max_frames;
            default:          prdata = '0;
        endcase
    end

    // Front: scale each sample and build block sums.
    bss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_s_sample (s_axis_tdata),
        .i_s_last   (s_axis_tlast),
        .i_q_status (q_status),
        .o_push     (push),
        .o_blk      (push_blk)
    );

    // Queue: hold finished blocks until the back is free.
    bss_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_blk    (push_blk),
        .i_pop    (pop),
        .o_blk    (pop_blk),
        .o_status (q_status)
    );

    // Back: take the mean, judge the block, track the open segment.
    bss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_blk      (pop_blk),
        .o_pop      (pop),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_noisy    (out_noisy),
        .o_level    (out_level),
        .o_count    (out_count),
        .o_event    (out_event),
        .o_frames   (out_frames),
        .o_end      (out_end)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-1-LEVEL_W-CNT_W-LEN_W){1'b0}},
                           out_frames, out_count, out_level, out_noisy};
    assign m_axis_tuser = out_event;
    assign m_axis_tlast = out_end;

endmodule
